>>> hdl/graph_hop_limit_check_top_assert.svh
// assertion macros shared by the hop-limit checker
`ifndef GRAPH_HOP_LIMIT_CHECK_TOP_ASSERT_SVH
`define GRAPH_HOP_LIMIT_CHECK_TOP_ASSERT_SVH

// condition in one cycle implies a consequence in the next cycle
`define GHLC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that holds at every clock edge out of reset
`define GHLC_ASSERT_NOW(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

>>> hdl/ghlc_pkg.sv
// shared types and codes for the graph hop-limit checker
package ghlc_pkg;

   // request kinds
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   // field widths
   localparam int unsigned NODE_FIELD_W  = 7;
   localparam int unsigned COUNT_FIELD_W = 8;
   localparam int unsigned HOP_FIELD_W   = 7;

   // control register indexes
   typedef enum logic {
      REG_NODE_COUNT = 1'b0,
      REG_HOP_LIMIT  = 1'b1
   } reg_idx_type;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_EDGE_A   = 8'b0000_0010,
      ST_EDGE_B   = 8'b0000_0100,
      ST_SRC_INIT = 8'b0000_1000,
      ST_SCAN     = 8'b0001_0000,
      ST_LEVEL    = 8'b0010_0000,
      ST_CHECK    = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

endpackage

>>> hdl/graph_hop_limit_check_top.sv
// Usage: an undirected graph is loaded one edge request at a time into a bit
// adjacency memory (one row per node). An evaluate request runs a level-by-level
// breadth-first search from each node below node_count until one fails, and
// returns one result, all_within, that is 1 when every pair of distinct nodes
// lies within hop_limit hops. Edge requests return nothing. Requests use
// req_valid/req_ready, results rsp_valid/rsp_ready, and node_count and
// hop_limit sit on the csr_ port. An edge request is a read-modify-write of
// two rows on the single memory write port, so req_ready stays low through
// ST_EDGE_A and ST_EDGE_B after it. An evaluate request keeps req_ready low
// while, for each source, ST_SRC_INIT seeds the search, each level (at most
// hop_limit) scans all n rows, where n is the node count, through the memory
// read port one row a cycle, drains the last read and closes in ST_LEVEL, and
// ST_CHECK tests the reached set. The result is registered from ST_DONE once
// the output slot is free, as req_ready returns and the matrix is cleared.
// Reset: node_count 1, hop_limit 7, the matrix reads as all zero (per-row valid
// bits) and no result is pending. A stalled receiver holds the result; edge
// requests are still taken, and a finished evaluate waits for the slot to free.
module graph_hop_limit_check_top
   import ghlc_pkg::*;
#(
   parameter int unsigned MAX_NODES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [6:0]  req_node_a,
   input  logic [6:0]  req_node_b,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_all_within,
   // control registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned NODE_W = $clog2(MAX_NODES);
   localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
   localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

   state_type                state_ff, state_in;
   logic [COUNT_FIELD_W-1:0] node_count_ff, node_count_in;
   logic [HOP_FIELD_W-1:0]   hop_limit_ff, hop_limit_in;
   logic [NODE_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         src_ff, src_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [HOP_FIELD_W-1:0]   level_ff, level_in;
   logic [MAX_NODES-1:0]     mask_ff, mask_in;
   logic [MAX_NODES-1:0]     reached_ff, reached_in;
   logic [MAX_NODES-1:0]     frontier_ff, frontier_in;
   logic [MAX_NODES-1:0]     next_ff, next_in;
   logic [MAX_NODES-1:0]     row_vld_ff, row_vld_in;
   logic                     pend_ff, pend_in;
   logic [NODE_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                     ok_ff, ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_all_within_ff, rsp_all_within_in;

   // adjacency memory and its registered read port
   logic [MAX_NODES-1:0]     adj_mem [MAX_NODES];
   logic [MAX_NODES-1:0]     rd_data_ff;
   logic                     rd_vld_ff;
   logic [NODE_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [NODE_W-1:0]        wr_addr;
   logic [MAX_NODES-1:0]     wr_data;

   // helpers
   logic [MAX_NODES-1:0]     row_rd;
   logic [MAX_NODES-1:0]     fresh;
   logic [CNT_W-1:0]         n_clamp;
   logic [CNT_W-1:0]         src_nxt;
   logic [HOP_FIELD_W-1:0]   level_nxt;
   logic [NODE_W-1:0]        req_a_idx, req_b_idx;
   logic                     ends_ok;
   reg_idx_type              csr_idx;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_all_within = rsp_all_within_ff;
   assign csr_pready     = 1'b1;
   assign csr_idx        = reg_idx_type'(csr_paddr[2]);

   // rows never written since the last clear read as zero
   assign row_rd    = rd_vld_ff ? rd_data_ff : '0;
   assign fresh     = next_ff & mask_ff & ~reached_ff;
   assign src_nxt   = CNT_W'(src_ff + 1'b1);
   assign level_nxt = HOP_FIELD_W'(level_ff + 1'b1);
   assign req_a_idx = NODE_W'(req_node_a);
   assign req_b_idx = NODE_W'(req_node_b);
   assign ends_ok   = (32'(req_node_a) < 32'(MAX_NODES)) && (32'(req_node_b) < 32'(MAX_NODES));
   assign n_clamp   = (32'(node_count_ff) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : CNT_W'(node_count_ff);

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_NODE_COUNT: csr_prdata = 32'(node_count_ff);
         REG_HOP_LIMIT:  csr_prdata = 32'(hop_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer and next-state logic
   always_comb begin
      state_in          = state_ff;
      node_count_in     = node_count_ff;
      hop_limit_in      = hop_limit_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      n_in              = n_ff;
      src_in            = src_ff;
      scan_in           = scan_ff;
      level_in          = level_ff;
      mask_in           = mask_ff;
      reached_in        = reached_ff;
      frontier_in       = frontier_ff;
      next_in           = next_ff;
      row_vld_in        = row_vld_ff;
      pend_in           = 1'b0;
      pend_idx_in       = pend_idx_ff;
      ok_in             = ok_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_all_within_in = rsp_all_within_ff;
      rd_addr           = scan_ff[NODE_W-1:0];
      wr_en             = 1'b0;
      wr_addr           = a_ff;
      wr_data           = row_rd | (ROW_ONE << b_ff);

      // control register writes
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_NODE_COUNT: node_count_in = csr_pwdata[COUNT_FIELD_W-1:0];
            REG_HOP_LIMIT:  hop_limit_in  = csr_pwdata[HOP_FIELD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_a_idx;
            if (req_valid) begin
               a_in = req_a_idx;
               b_in = req_b_idx;
               if (req_kind == KIND_EVAL) begin
                  n_in   = n_clamp;
                  src_in = '0;
                  ok_in  = 1'b1;
                  for (int k = 0; k < MAX_NODES; k++) begin
                     mask_in[k] = (32'(k) < 32'(n_clamp));
                  end
                  state_in = (n_clamp == '0) ? ST_DONE : ST_SRC_INIT;
               end else if (ends_ok) begin
                  state_in = ST_EDGE_A;
               end
            end
         end
         // row a gets bit b, then read row b
         ST_EDGE_A: begin
            wr_en            = 1'b1;
            wr_addr          = a_ff;
            wr_data          = row_rd | (ROW_ONE << b_ff);
            row_vld_in[a_ff] = 1'b1;
            rd_addr          = b_ff;
            state_in         = ST_EDGE_B;
         end
         // row b gets bit a
         ST_EDGE_B: begin
            wr_en            = 1'b1;
            wr_addr          = b_ff;
            wr_data          = row_rd | (ROW_ONE << a_ff);
            row_vld_in[b_ff] = 1'b1;
            state_in         = ST_IDLE;
         end
         // start a search from the current source
         ST_SRC_INIT: begin
            reached_in  = ROW_ONE << src_ff[NODE_W-1:0];
            frontier_in = ROW_ONE << src_ff[NODE_W-1:0];
            level_in    = '0;
            next_in     = '0;
            scan_in     = '0;
            state_in    = (hop_limit_ff == '0) ? ST_CHECK : ST_SCAN;
         end
         // one row per cycle; merge rows of frontier nodes
         ST_SCAN: begin
            if (scan_ff < n_ff) begin
               rd_addr     = scan_ff[NODE_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[NODE_W-1:0];
               scan_in     = CNT_W'(scan_ff + 1'b1);
            end
            if (pend_ff && frontier_ff[pend_idx_ff]) begin
               next_in = next_ff | row_rd;
            end
            if ((scan_ff == n_ff) && !pend_ff) begin
               state_in = ST_LEVEL;
            end
         end
         // close one level
         ST_LEVEL: begin
            reached_in  = reached_ff | fresh;
            frontier_in = fresh;
            level_in    = level_nxt;
            next_in     = '0;
            scan_in     = '0;
            if ((fresh == '0) || (level_nxt >= hop_limit_ff)) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         // every node must have been reached
         ST_CHECK: begin
            if (reached_ff != mask_ff) begin
               ok_in    = 1'b0;
               state_in = ST_DONE;
            end else if (src_nxt == n_ff) begin
               state_in = ST_DONE;
            end else begin
               src_in   = src_nxt;
               state_in = ST_SRC_INIT;
            end
         end
         // hand over the result and clear the matrix
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_all_within_in = ok_ff;
               row_vld_in        = '0;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= COUNT_FIELD_W'(1);
         hop_limit_ff  <= HOP_FIELD_W'(7);
         row_vld_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         hop_limit_ff  <= hop_limit_in;
         row_vld_ff    <= row_vld_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff              <= a_in;
      b_ff              <= b_in;
      n_ff              <= n_in;
      src_ff            <= src_in;
      scan_ff           <= scan_in;
      level_ff          <= level_in;
      mask_ff           <= mask_in;
      reached_ff        <= reached_in;
      frontier_ff       <= frontier_in;
      next_ff           <= next_in;
      pend_idx_ff       <= pend_idx_in;
      ok_ff             <= ok_in;
      rsp_all_within_ff <= rsp_all_within_in;
   end

   // adjacency memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= adj_mem[rd_addr];
      rd_vld_ff  <= row_vld_ff[rd_addr];
   end

endmodule

>>> hdl/ghlc_checker.sv
// port-level assertion checker for the graph hop-limit checker, with its bind
`include "graph_hop_limit_check_top_assert.svh"

module ghlc_checker
   import ghlc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_all_within,
   input logic        csr_pready
);

   // a stalled result holds
   `GHLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_all_within), "result changed while stalled")

   // an evaluate request keeps the block busy
   `GHLC_ASSERT_NEXT(a_eval_busy, req_valid && req_ready && (req_kind == KIND_EVAL), !req_ready, "ready right after evaluate request")

   // an edge request never produces a result
   `GHLC_ASSERT_NEXT(a_edge_silent, req_valid && req_ready && (req_kind == KIND_EDGE) && !rsp_valid, !rsp_valid, "result raised by edge request")

   // the register port never waits
   `GHLC_ASSERT_NOW(a_pready_high, csr_pready, "register port not ready")

endmodule

bind graph_hop_limit_check_top ghlc_checker u_ghlc_checker (.*);
